@@ rtl/core/csvs_pkg.sv @@
// Shared constants, character classes and controller/datapath handshake types
// for the CSV row cell splitter. No dependencies.

package csvs_pkg;

   localparam int PENDING_DEPTH_DEFAULT = 16;

   localparam int BYTE_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int USER_W     = 4;

   localparam logic [BYTE_W-1:0] SEPARATOR_RESET = 8'd44;

   // Register index decoded from the word address bit.
   localparam logic REG_SEPARATOR = 1'b0;

   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;
   localparam logic [BYTE_W-1:0] CH_EQUAL = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   function automatic logic is_space(input logic [BYTE_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
             (c == CH_FF) || (c == CH_CR);
   endfunction

   // Bytes that make a leading apostrophe get dropped.
   function automatic logic is_danger(input logic [BYTE_W-1:0] c);
      return (c == CH_EQUAL) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_AT) ||
             (c == CH_TAB) || (c == CH_CR);
   endfunction

   // How the current byte is handled outside the held-quote check.
   typedef enum logic [3:0] {
      TK_QUOTE_MARK,
      TK_EMIT,
      TK_SEPARATOR,
      TK_OPEN,
      TK_SKIP,
      TK_PUSH,
      TK_OVERFLOW,
      TK_FLUSH,
      TK_PLAIN
   } take_kind_type;

   typedef enum logic [1:0] {
      SRC_BYTE,
      SRC_QUOTE,
      SRC_PENDING
   } emit_src_type;

   typedef struct packed {
      logic         latch;
      logic         clr_quote_held;
      logic         close_quotes;
      logic         take_apply;
      logic         emit_go;
      emit_src_type emit_src;
      logic         emit_ovf;
      logic         out_last;
      logic         set_has_content;
      logic         flush_step;
      logic         flush_end;
      logic         fin_go;
      logic         fin_row;
   } dp_cmd_type;

   typedef struct packed {
      logic          quote_held;
      logic          quote_consume;
      logic          chopped;
      logic          row_end;
      take_kind_type take_kind;
      logic          emit_done;
      logic          flush_last;
      logic          fin_done;
   } dp_status_type;

endpackage

@@ rtl/core/csvs_csr.sv @@
// Configuration register bank of the CSV row cell splitter: the separator byte.
// Depends on csvs_pkg.

module csvs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [csvs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [csvs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [csvs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [csvs_pkg::BYTE_W-1:0]         separator
);

   logic [csvs_pkg::BYTE_W-1:0] sep_ff;
   logic [csvs_pkg::BYTE_W-1:0] sep_in;
   logic                        reg_index;

   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign separator  = sep_ff;

   always_comb begin
      sep_in = sep_ff;
      if (csr_psel && csr_penable && csr_pwrite && (reg_index == csvs_pkg::REG_SEPARATOR)) begin
         sep_in = csr_pwdata[csvs_pkg::BYTE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == csvs_pkg::REG_SEPARATOR) begin
         csr_prdata = csvs_pkg::CSR_DATA_W'(sep_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= csvs_pkg::SEPARATOR_RESET;
      end else begin
         sep_ff <= sep_in;
      end
   end

endmodule

@@ rtl/core/csvs_ctrl.sv @@
// Sequencing state machine of the CSV row cell splitter: walks each accepted
// byte through quote, take, flush and cell-finish steps. Depends on csvs_pkg.

module csvs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  csvs_pkg::dp_status_type status,
   output csvs_pkg::dp_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_QUOTE   = 7'b0000010,
      ST_TAKE    = 7'b0000100,
      ST_FLUSH   = 7'b0001000,
      ST_CHAR    = 7'b0010000,
      ST_SEP_FIN = 7'b0100000,
      ST_ROW_FIN = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   state_type after_byte;
   logic      ovf_ff;
   logic      ovf_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign after_byte = status.row_end ? ST_ROW_FIN : ST_IDLE;

   always_comb begin
      state_in     = state_ff;
      ovf_in       = ovf_ff;
      cmd          = '0;
      cmd.emit_src = csvs_pkg::SRC_BYTE;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch = req_tvalid;
            if (req_tvalid) begin
               state_in = status.quote_held ? ST_QUOTE : ST_TAKE;
            end
         end
         ST_QUOTE: begin
            cmd.clr_quote_held = 1'b1;
            if (status.quote_consume) begin
               // A second quote after a held one is one literal quote.
               cmd.emit_go  = 1'b1;
               cmd.emit_src = csvs_pkg::SRC_QUOTE;
               cmd.out_last = !status.row_end;
               if (status.emit_done) begin
                  state_in = after_byte;
               end
            end else begin
               cmd.close_quotes = 1'b1;
               state_in = status.chopped ? ST_ROW_FIN : ST_TAKE;
            end
         end
         ST_TAKE: begin
            case (status.take_kind)
               csvs_pkg::TK_EMIT: begin
                  cmd.emit_go  = 1'b1;
                  cmd.out_last = !status.row_end;
                  if (status.emit_done) begin
                     state_in = after_byte;
                  end
               end
               csvs_pkg::TK_PLAIN: begin
                  cmd.emit_go         = 1'b1;
                  cmd.out_last        = !status.row_end;
                  cmd.set_has_content = status.emit_done;
                  if (status.emit_done) begin
                     state_in = after_byte;
                  end
               end
               csvs_pkg::TK_SEPARATOR: begin
                  state_in = ST_SEP_FIN;
               end
               csvs_pkg::TK_FLUSH: begin
                  ovf_in   = 1'b0;
                  state_in = ST_FLUSH;
               end
               csvs_pkg::TK_OVERFLOW: begin
                  ovf_in   = 1'b1;
                  state_in = ST_FLUSH;
               end
               csvs_pkg::TK_QUOTE_MARK, csvs_pkg::TK_OPEN,
               csvs_pkg::TK_SKIP, csvs_pkg::TK_PUSH: begin
                  cmd.take_apply = 1'b1;
                  state_in       = after_byte;
               end
               default: begin
                  state_in = after_byte;
               end
            endcase
         end
         ST_FLUSH: begin
            cmd.emit_go  = 1'b1;
            cmd.emit_src = csvs_pkg::SRC_PENDING;
            cmd.emit_ovf = ovf_ff;
            if (status.emit_done) begin
               if (status.flush_last) begin
                  cmd.flush_end = 1'b1;
                  state_in      = ST_CHAR;
               end else begin
                  cmd.flush_step = 1'b1;
               end
            end
         end
         ST_CHAR: begin
            cmd.emit_go         = 1'b1;
            cmd.emit_ovf        = ovf_ff;
            cmd.out_last        = !status.row_end;
            cmd.set_has_content = status.emit_done;
            if (status.emit_done) begin
               state_in = after_byte;
            end
         end
         ST_SEP_FIN: begin
            cmd.fin_go   = 1'b1;
            cmd.out_last = !status.row_end;
            if (status.fin_done) begin
               state_in = after_byte;
            end
         end
         ST_ROW_FIN: begin
            cmd.fin_go   = 1'b1;
            cmd.fin_row  = 1'b1;
            cmd.out_last = 1'b1;
            if (status.fin_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

@@ rtl/core/csvs_datapath.sv @@
// Datapath of the CSV row cell splitter: cell state flags, the trailing
// whitespace buffer, the content emitter and the result register. Depends on csvs_pkg.

module csvs_datapath #(
   parameter int PENDING_DEPTH = csvs_pkg::PENDING_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [csvs_pkg::BYTE_W-1:0]       req_tdata,
   input  logic                              req_tlast,
   input  logic [csvs_pkg::BYTE_W-1:0]       separator,
   input  csvs_pkg::dp_cmd_type              cmd,
   output csvs_pkg::dp_status_type           status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [csvs_pkg::BYTE_W-1:0]       rsp_tdata,
   output logic [csvs_pkg::USER_W-1:0]       rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int IDX_W = $clog2(PENDING_DEPTH);
   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PENDING_DEPTH);

   typedef struct packed {
      logic [csvs_pkg::BYTE_W-1:0] cell_byte;
      logic                        byte_valid;
      logic                        cell_done;
      logic                        row_done;
      logic                        space_overflow;
      logic                        last_of_input;
   } result_type;

   logic [csvs_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        end_ff, end_in;
   logic                        in_quotes_ff, in_quotes_in;
   logic                        was_quoted_ff, was_quoted_in;
   logic                        quote_held_ff, quote_held_in;
   logic                        has_content_ff, has_content_in;
   logic [1:0]                  count_ff, count_in;
   logic                        apos_held_ff, apos_held_in;
   logic [CNT_W-1:0]            pend_cnt_ff, pend_cnt_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [csvs_pkg::BYTE_W-1:0] rd_data_ff;
   logic                        out_valid_ff, out_valid_in;
   result_type                  out_ff, out_in;

   logic [csvs_pkg::BYTE_W-1:0] pending_mem [PENDING_DEPTH];
   logic                        mem_we;

   logic                        slot_free;
   logic                        chopped;
   logic [csvs_pkg::BYTE_W-1:0] emit_char;
   logic                        absorb;
   logic                        release_apos;
   logic                        emit_fire;
   csvs_pkg::take_kind_type     kind;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign chopped   = end_ff && (byte_ff == csvs_pkg::CH_CR);

   always_comb begin
      case (cmd.emit_src)
         csvs_pkg::SRC_BYTE:    emit_char = byte_ff;
         csvs_pkg::SRC_QUOTE:   emit_char = csvs_pkg::CH_QUOTE;
         csvs_pkg::SRC_PENDING: emit_char = rd_data_ff;
         default:               emit_char = byte_ff;
      endcase
   end

   // An apostrophe as the first value byte is held back; it is released ahead of
   // the next byte unless that byte is one of the formula-trigger characters.
   assign absorb       = (count_ff == 2'd0) && (emit_char == csvs_pkg::CH_APOS);
   assign release_apos = !absorb && apos_held_ff && !csvs_pkg::is_danger(emit_char);
   assign emit_fire    = cmd.emit_go && (absorb || slot_free);

   always_comb begin
      if (chopped) begin
         // A CR on the last byte of the row is dropped wherever it stands.
         kind = csvs_pkg::TK_SKIP;
      end else if (in_quotes_ff) begin
         kind = (byte_ff == csvs_pkg::CH_QUOTE) ? csvs_pkg::TK_QUOTE_MARK : csvs_pkg::TK_EMIT;
      end else if (byte_ff == separator) begin
         kind = csvs_pkg::TK_SEPARATOR;
      end else if (was_quoted_ff) begin
         kind = csvs_pkg::TK_EMIT;
      end else if ((byte_ff == csvs_pkg::CH_QUOTE) && !has_content_ff) begin
         kind = csvs_pkg::TK_OPEN;
      end else if (csvs_pkg::is_space(byte_ff)) begin
         if (!has_content_ff || end_ff) begin
            kind = csvs_pkg::TK_SKIP;
         end else if (pend_cnt_ff < CNT_FULL) begin
            kind = csvs_pkg::TK_PUSH;
         end else begin
            kind = csvs_pkg::TK_OVERFLOW;
         end
      end else if (pend_cnt_ff != '0) begin
         kind = csvs_pkg::TK_FLUSH;
      end else begin
         kind = csvs_pkg::TK_PLAIN;
      end
   end

   always_comb begin
      status.quote_held    = quote_held_ff;
      status.quote_consume = !chopped && (byte_ff == csvs_pkg::CH_QUOTE);
      status.chopped       = chopped;
      status.row_end       = end_ff;
      status.take_kind     = kind;
      status.emit_done     = emit_fire && !release_apos;
      status.flush_last    = (CNT_W'(idx_ff) + CNT_W'(1)) == pend_cnt_ff;
      status.fin_done      = cmd.fin_go && slot_free && !apos_held_ff;
   end

   always_comb begin
      byte_in        = byte_ff;
      end_in         = end_ff;
      in_quotes_in   = in_quotes_ff;
      was_quoted_in  = was_quoted_ff;
      quote_held_in  = quote_held_ff;
      has_content_in = has_content_ff;
      count_in       = count_ff;
      apos_held_in   = apos_held_ff;
      pend_cnt_in    = pend_cnt_ff;
      idx_in         = idx_ff;
      mem_we         = 1'b0;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_in         = out_ff;

      if (cmd.latch) begin
         byte_in = req_tdata;
         end_in  = req_tlast;
      end
      if (cmd.clr_quote_held) begin
         quote_held_in = 1'b0;
      end
      if (cmd.close_quotes) begin
         in_quotes_in = 1'b0;
      end

      if (cmd.take_apply) begin
         case (kind)
            csvs_pkg::TK_QUOTE_MARK: begin
               if (end_ff) begin
                  in_quotes_in = 1'b0;
               end else begin
                  quote_held_in = 1'b1;
               end
            end
            csvs_pkg::TK_OPEN: begin
               in_quotes_in  = 1'b1;
               was_quoted_in = 1'b1;
            end
            csvs_pkg::TK_PUSH: begin
               mem_we      = 1'b1;
               pend_cnt_in = pend_cnt_ff + CNT_W'(1);
            end
            default: begin
            end
         endcase
      end

      if (emit_fire) begin
         if (absorb) begin
            apos_held_in = 1'b1;
            count_in     = 2'd1;
         end else if (release_apos) begin
            apos_held_in     = 1'b0;
            out_valid_in     = 1'b1;
            out_in           = '0;
            out_in.cell_byte = csvs_pkg::CH_APOS;
            out_in.byte_valid = 1'b1;
         end else begin
            apos_held_in          = 1'b0;
            out_valid_in          = 1'b1;
            out_in                = '0;
            out_in.cell_byte      = emit_char;
            out_in.byte_valid     = 1'b1;
            out_in.space_overflow = cmd.emit_ovf;
            out_in.last_of_input  = cmd.out_last;
            if (count_ff != 2'd2) begin
               count_in = count_ff + 2'd1;
            end
         end
      end

      if (cmd.set_has_content) begin
         has_content_in = 1'b1;
      end
      if (cmd.flush_step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.flush_end) begin
         idx_in      = '0;
         pend_cnt_in = '0;
      end

      if (cmd.fin_go && slot_free) begin
         out_valid_in = 1'b1;
         out_in       = '0;
         if (apos_held_ff) begin
            // A cell whose whole value is one apostrophe keeps it.
            apos_held_in      = 1'b0;
            out_in.cell_byte  = csvs_pkg::CH_APOS;
            out_in.byte_valid = 1'b1;
         end else begin
            out_in.cell_done     = 1'b1;
            out_in.row_done      = cmd.fin_row;
            out_in.last_of_input = cmd.out_last;
            in_quotes_in         = 1'b0;
            was_quoted_in        = 1'b0;
            quote_held_in        = 1'b0;
            has_content_in       = 1'b0;
            count_in             = 2'd0;
            pend_cnt_in          = '0;
            idx_in               = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff   <= 1'b0;
         was_quoted_ff  <= 1'b0;
         quote_held_ff  <= 1'b0;
         has_content_ff <= 1'b0;
         count_ff       <= 2'd0;
         apos_held_ff   <= 1'b0;
         pend_cnt_ff    <= '0;
         idx_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         in_quotes_ff   <= in_quotes_in;
         was_quoted_ff  <= was_quoted_in;
         quote_held_ff  <= quote_held_in;
         has_content_ff <= has_content_in;
         count_ff       <= count_in;
         apos_held_ff   <= apos_held_in;
         pend_cnt_ff    <= pend_cnt_in;
         idx_ff         <= idx_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
      out_ff  <= out_in;
   end

   // Whitespace buffer: written at the fill count, read at the next flush index.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pending_mem[pend_cnt_ff[IDX_W-1:0]] <= byte_ff;
      end
      rd_data_ff <= pending_mem[idx_in];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.cell_byte;
   assign rsp_tuser  = {out_ff.last_of_input, out_ff.space_overflow,
                        out_ff.cell_done, out_ff.byte_valid};
   assign rsp_tlast  = out_ff.row_done;

endmodule

@@ rtl/core/csv_row_cell_splitter.sv @@
// CSV row cell splitter. Bytes of one row enter on the req_ stream, one per
// beat, with req_tlast on the last byte of the row. Cell contents leave on the
// rsp_ stream, one content byte or one end-of-cell marker per beat. Quoted cells
// are unescaped, unquoted cells are trimmed, a final CR is dropped and a leading
// apostrophe before = + - @ tab or CR is removed. The separator byte is set
// through the csr_ register port (reset value is a comma).
// Timing: a byte is taken in the idle cycle and worked on from the next cycle;
// a byte that ends a cell on the separator then goes on to a cell-finish step.
// A released apostrophe and the row-end marker each add a beat of their own.
// A held quote check is a step of its own, and a second quote is emitted in
// that check step itself. A flush of the trailing whitespace buffer emits the
// buffered bytes one per step before the byte that ends the run. Bytes are taken
// one at a time, never back to back.
// A registered output stage holds each result; when the receiver stalls the
// sequencer waits on it and req_tready stays low until the byte is done.
// Reset (synchronous, active high) clears all cell and row state and returns the
// separator to its reset value; buffered whitespace needs no clearing.
// Depends on csvs_pkg, csvs_csr, csvs_ctrl and csvs_datapath.

module csv_row_cell_splitter #(
   parameter int PENDING_DEPTH = csvs_pkg::PENDING_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [csvs_pkg::BYTE_W-1:0]      req_tdata,    // row_byte
   input  logic                             req_tlast,    // is_row_end
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [csvs_pkg::BYTE_W-1:0]      rsp_tdata,    // cell_byte
   // From bit 0: byte_valid, cell_done, space_overflow, last_of_input.
   output logic [csvs_pkg::USER_W-1:0]      rsp_tuser,
   output logic                             rsp_tlast,    // row_done
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [csvs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [csvs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [csvs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   logic [csvs_pkg::BYTE_W-1:0] separator;
   csvs_pkg::dp_cmd_type        cmd;
   csvs_pkg::dp_status_type     status;

   // Register bank holding the separator byte.
   csvs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .separator   (separator)
   );

   // The sequencer owns the input handshake and steps the datapath through
   // each byte's work.
   csvs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath owns the cell state, the whitespace buffer and the output stage.
   csvs_datapath #(
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .separator  (separator),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ verif/csv_row_cell_splitter_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for csv_row_cell_splitter: drives rows of text into the
// req_ stream, predicts every rsp_ beat and compares them field by field.
// Depends on csvs_pkg and the csv_row_cell_splitter RTL.

module csv_row_cell_splitter_test;

   localparam int SPACE_DEPTH = csvs_pkg::PENDING_DEPTH_DEFAULT;
   // The separator register is register 0; the word address bit selects it.
   localparam logic [csvs_pkg::CSR_ADDR_W-1:0] SEPARATOR_ADDR =
      {csvs_pkg::REG_SEPARATOR, 2'b00};
   localparam int unsigned CYCLE_LIMIT = 500000;
   // A whitespace flush emits one beat per buffered byte, so the quiet time
   // before a register write or the end of the run covers a full buffer.
   localparam int unsigned SETTLE_CYCLES = 2 * SPACE_DEPTH + 10;
   localparam int unsigned HOLD_AFTER_BYTES = 40;
   localparam int unsigned HOLD_CYCLES = 250;
   localparam int unsigned BYTES_PER_PHASE = 24;

   typedef logic [csvs_pkg::BYTE_W-1:0] octet_type;
   typedef octet_type octet_queue_type[$];

   // One result beat as the block reports it.
   typedef struct packed {
      octet_type data;
      logic      valid;
      logic      cell_end;
      logic      row_end;
      logic      overflow;
      logic      last;
   } cell_beat_type;

   // Tracks the splitter's cell state, turns each accepted row byte into the
   // beats it must cause and holds them until the rsp_ side delivers them.
   class cell_beat_board_type;
      octet_type     separator;
      bit            in_quoted_region;
      bit            opened_by_quote;
      bit            quote_pending;
      bit            value_started;
      int unsigned   value_len;
      bit            apos_pending;
      octet_type     space_buf[SPACE_DEPTH];
      int unsigned   space_fill;
      cell_beat_type step_beats[$];
      cell_beat_type awaited[$];
      int unsigned   bytes_taken;
      int unsigned   mismatches;

      function new();
         separator = csvs_pkg::SEPARATOR_RESET;
         in_quoted_region = 1'b0;
         opened_by_quote = 1'b0;
         quote_pending = 1'b0;
         value_started = 1'b0;
         value_len = 0;
         apos_pending = 1'b0;
         space_fill = 0;
         bytes_taken = 0;
         mismatches = 0;
      endfunction

      function bit trimmable(octet_type c);
         case (c)
            csvs_pkg::CH_SPACE, csvs_pkg::CH_TAB, csvs_pkg::CH_LF, csvs_pkg::CH_VT,
            csvs_pkg::CH_FF, csvs_pkg::CH_CR: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      // A leading apostrophe is dropped when one of these bytes follows it.
      function bit formula_lead(octet_type c);
         case (c)
            csvs_pkg::CH_EQUAL, csvs_pkg::CH_PLUS, csvs_pkg::CH_MINUS, csvs_pkg::CH_AT,
            csvs_pkg::CH_TAB, csvs_pkg::CH_CR: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void put(octet_type b, bit valid, bit cell_end, bit row_end, bit overflow);
         cell_beat_type beat;
         beat.data = b;
         beat.valid = valid;
         beat.cell_end = cell_end;
         beat.row_end = row_end;
         beat.overflow = overflow;
         beat.last = 1'b0;
         step_beats.push_back(beat);
      endfunction

      // The first value byte of a cell being an apostrophe is held back until
      // the next value byte shows whether it must go.
      function void emit_value(octet_type c, bit overflow);
         if (value_len == 0 && c == csvs_pkg::CH_APOS) begin
            apos_pending = 1'b1;
            value_len = 1;
            return;
         end
         if (apos_pending) begin
            apos_pending = 1'b0;
            if (!formula_lead(c)) put(csvs_pkg::CH_APOS, 1'b1, 1'b0, 1'b0, 1'b0);
         end
         put(c, 1'b1, 1'b0, 1'b0, overflow);
         if (value_len < 2) value_len++;
      endfunction

      function void flush_spaces(bit overflow);
         for (int i = 0; i < space_fill; i++) emit_value(space_buf[i], overflow);
         space_fill = 0;
      endfunction

      function void close_cell(bit row_end);
         if (apos_pending) put(csvs_pkg::CH_APOS, 1'b1, 1'b0, 1'b0, 1'b0);
         put('0, 1'b0, 1'b1, row_end, 1'b0);
         in_quoted_region = 1'b0;
         opened_by_quote = 1'b0;
         quote_pending = 1'b0;
         value_started = 1'b0;
         value_len = 0;
         apos_pending = 1'b0;
         space_fill = 0;
      endfunction

      function void take(octet_type c, bit row_end);
         if (in_quoted_region) begin
            if (c != csvs_pkg::CH_QUOTE) emit_value(c, 1'b0);
            else if (row_end) in_quoted_region = 1'b0;
            else quote_pending = 1'b1;
            return;
         end
         if (c == separator) begin
            close_cell(1'b0);
            return;
         end
         // Everything after a closing quote is kept as it stands.
         if (opened_by_quote) begin
            emit_value(c, 1'b0);
            return;
         end
         if (c == csvs_pkg::CH_QUOTE && !value_started) begin
            in_quoted_region = 1'b1;
            opened_by_quote = 1'b1;
            return;
         end
         if (trimmable(c)) begin
            if (!value_started || row_end) return;
            if (space_fill < SPACE_DEPTH) begin
               space_buf[space_fill] = c;
               space_fill++;
            end else begin
               flush_spaces(1'b1);
               emit_value(c, 1'b1);
            end
            return;
         end
         flush_spaces(1'b0);
         emit_value(c, 1'b0);
         value_started = 1'b1;
      endfunction

      function void note_row_byte(octet_type c, bit row_end);
         bit chopped;
         bit consumed;
         cell_beat_type final_beat;
         chopped = row_end && c == csvs_pkg::CH_CR;
         consumed = chopped;
         step_beats.delete();
         bytes_taken++;
         // A quote seen inside quotes waits for the next byte: a second quote
         // makes it literal, anything else closes the quoted region.
         if (quote_pending) begin
            quote_pending = 1'b0;
            if (!chopped && c == csvs_pkg::CH_QUOTE) begin
               emit_value(csvs_pkg::CH_QUOTE, 1'b0);
               consumed = 1'b1;
            end else begin
               in_quoted_region = 1'b0;
            end
         end
         if (!consumed) take(c, row_end);
         if (row_end) close_cell(1'b1);
         if (step_beats.size() != 0) begin
            final_beat = step_beats.pop_back();
            final_beat.last = 1'b1;
            step_beats.push_back(final_beat);
         end
         foreach (step_beats[i]) awaited.push_back(step_beats[i]);
      endfunction

      function void compare_field(string name, octet_type want, octet_type got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void compare_flag(string name, logic want, logic got);
         if (got !== want) begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_cell_beat(octet_type data, logic [csvs_pkg::USER_W-1:0] user,
                                    logic row_done);
         cell_beat_type want;
         if (awaited.size() == 0) begin
            $error("result beat with nothing expected: data %0h user %0h last %0b",
                   data, user, row_done);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         compare_field("cell_byte", want.data, data);
         compare_flag("byte_valid", want.valid, user[0]);
         compare_flag("cell_done", want.cell_end, user[1]);
         compare_flag("space_overflow", want.overflow, user[2]);
         compare_flag("last_of_input", want.last, user[3]);
         compare_flag("row_done", want.row_end, row_done);
      endfunction
   endclass

   // All inputs of the block start at known values.
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   octet_type                            req_tdata = '0;     // row_byte
   logic                                 req_tlast = 1'b0;   // is_row_end
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   octet_type                            rsp_tdata;          // cell_byte
   // From bit 0: byte_valid, cell_done, space_overflow, last_of_input.
   logic [csvs_pkg::USER_W-1:0]          rsp_tuser;
   logic                                 rsp_tlast;          // row_done
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [csvs_pkg::CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [csvs_pkg::CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [csvs_pkg::CSR_DATA_W-1:0]      csr_prdata;
   logic                                 csr_pready;

   cell_beat_board_type beats;
   octet_queue_type     row_text;
   int unsigned         req_gap_pct = 0;
   int unsigned         rsp_stall_pct = 0;
   int unsigned         hold_left = 0;
   bit                  hold_done = 1'b0;
   int unsigned         cycle_count = 0;

   csv_row_cell_splitter #(
      .PENDING_DEPTH(SPACE_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // A hung handshake or a lost beat ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side. Every accepted beat is checked against the oldest expected
   // one. The ready line stalls at random, and once, after enough row bytes
   // have gone in, it holds off for a long stretch so that the output stage
   // fills and the block has to stall its input while bytes keep being offered.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats.check_cell_beat(rsp_tdata, rsp_tuser, rsp_tlast);
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && beats.bytes_taken >= HOLD_AFTER_BYTES) begin
         rsp_tready <= 1'b0;
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offers one row byte, after a random number of idle cycles, and waits for
   // the beat to be taken. Valid stays high from one byte to the next when no
   // gap is drawn, so it is never lowered and raised in the same step.
   task automatic send_octet(input octet_type value, input logic row_end);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= row_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats.note_row_byte(value, row_end);
   endtask

   task automatic send_row();
      foreach (row_text[i]) send_octet(row_text[i], i == row_text.size() - 1);
   endtask

   // The block is idle once every expected beat has arrived and a full
   // whitespace flush would have had time to finish.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (beats.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: a setup phase, then an access phase with pready sampled.
   task automatic write_separator(input octet_type value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= SEPARATOR_ADDR;
      csr_pwdata <= {{(csvs_pkg::CSR_DATA_W - csvs_pkg::BYTE_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      beats.separator = value;
   endtask

   task automatic add_spaces(input int unsigned count);
      repeat (count) begin
         case ($urandom_range(5))
            0: row_text.push_back(csvs_pkg::CH_SPACE);
            1: row_text.push_back(csvs_pkg::CH_TAB);
            2: row_text.push_back(csvs_pkg::CH_LF);
            3: row_text.push_back(csvs_pkg::CH_VT);
            4: row_text.push_back(csvs_pkg::CH_FF);
            default: row_text.push_back(csvs_pkg::CH_CR);
         endcase
      end
   endtask

   // Value bytes lean toward the ones the splitter treats specially.
   function automatic octet_type pick_value_char(input octet_type separator);
      case ($urandom_range(11))
         0, 1, 2, 3: return octet_type'(8'h61 + $urandom_range(25));
         4: return csvs_pkg::CH_EQUAL;
         5: return csvs_pkg::CH_PLUS;
         6: return csvs_pkg::CH_MINUS;
         7: return csvs_pkg::CH_AT;
         8: return csvs_pkg::CH_APOS;
         9: return csvs_pkg::CH_QUOTE;
         10: return separator;
         default: return octet_type'($urandom_range(255));
      endcase
   endfunction

   // Random rows until about byte_goal bytes have gone in. Most rows are well
   // formed: quoted cells with doubled quotes, unquoted cells with padding and
   // now and then a whitespace run long enough to overflow the buffer, and
   // leading apostrophes. The rest are short runs of arbitrary bytes.
   task automatic run_rows(input int unsigned byte_goal);
      int unsigned sent;
      int unsigned n_cells;
      sent = 0;
      while (sent < byte_goal) begin
         row_text.delete();
         if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 8)) row_text.push_back(octet_type'($urandom_range(255)));
         end else begin
            n_cells = $urandom_range(1, 3);
            for (int k = 0; k < n_cells; k++) begin
               if ($urandom_range(3) == 0) add_spaces($urandom_range(1, 2));
               if ($urandom_range(9) < 3) begin
                  row_text.push_back(csvs_pkg::CH_QUOTE);
                  repeat ($urandom_range(0, 4)) begin
                     if ($urandom_range(4) == 0) begin
                        row_text.push_back(csvs_pkg::CH_QUOTE);
                        row_text.push_back(csvs_pkg::CH_QUOTE);
                     end else begin
                        row_text.push_back(pick_value_char(beats.separator));
                     end
                  end
                  // Now and then the quote is left open until the row ends.
                  if ($urandom_range(7) != 0) row_text.push_back(csvs_pkg::CH_QUOTE);
                  if ($urandom_range(4) == 0) row_text.push_back(pick_value_char(beats.separator));
               end else begin
                  if ($urandom_range(3) == 0) begin
                     row_text.push_back(csvs_pkg::CH_APOS);
                     if ($urandom_range(2) == 0) add_spaces(1);
                  end
                  repeat ($urandom_range(1, 4)) begin
                     row_text.push_back(pick_value_char(beats.separator));
                     if ($urandom_range(11) == 0) add_spaces($urandom_range(15, 19));
                     else if ($urandom_range(3) == 0) add_spaces($urandom_range(1, 3));
                  end
               end
               if (k != n_cells - 1) row_text.push_back(beats.separator);
            end
            case ($urandom_range(9))
               0, 1: row_text.push_back(beats.separator);
               2, 3: row_text.push_back(csvs_pkg::CH_CR);
               default: ;
            endcase
         end
         send_row();
         sent += row_text.size();
      end
      wait_until_drained();
   endtask

   initial begin
      octet_type seps[5];
      beats = new();
      seps = '{8'hFF, 8'h00, csvs_pkg::CH_QUOTE, 8'h3B, csvs_pkg::SEPARATOR_RESET};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_gap_pct = 31;
      rsp_stall_pct = 52;

      // Directed rows with the reset separator (a comma).
      // A leading apostrophe before '=' goes away; a quoted cell holds a doubled
      // quote; the row ends on a separator, which leaves an empty last cell.
      row_text = '{csvs_pkg::CH_APOS, csvs_pkg::CH_EQUAL, csvs_pkg::SEPARATOR_RESET,
                   csvs_pkg::CH_QUOTE, csvs_pkg::CH_QUOTE, csvs_pkg::CH_QUOTE,
                   csvs_pkg::CH_QUOTE, csvs_pkg::SEPARATOR_RESET};
      send_row();
      // A lone apostrophe stays; a quote after leading whitespace opens a
      // quoted cell, and a quote on the last byte closes it.
      row_text = '{csvs_pkg::CH_APOS, csvs_pkg::SEPARATOR_RESET, csvs_pkg::CH_SPACE,
                   csvs_pkg::CH_QUOTE, 8'h61, csvs_pkg::CH_QUOTE};
      send_row();
      // Extreme byte values, a quote after content taken literally, inner
      // whitespace kept, trailing whitespace dropped and a final CR dropped.
      row_text = '{8'hFF, csvs_pkg::CH_QUOTE, csvs_pkg::CH_SPACE, 8'h00,
                   csvs_pkg::CH_TAB, csvs_pkg::CH_CR};
      send_row();
      // Bytes after a closing quote are kept as they are, and a quote left
      // open runs to the end of the row.
      row_text = '{csvs_pkg::CH_QUOTE, 8'h78, csvs_pkg::CH_QUOTE, csvs_pkg::CH_SPACE,
                   csvs_pkg::CH_QUOTE, csvs_pkg::SEPARATOR_RESET, csvs_pkg::CH_QUOTE,
                   8'h7A};
      send_row();
      wait_until_drained();

      // Random phases, each under its own separator. The separator walks both
      // extremes and the quote byte, which turns every quote into a separator.
      foreach (seps[p]) begin
         if (p == 2) begin
            req_gap_pct = 52;
            rsp_stall_pct = 31;
         end else if (p == 4) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         write_separator(seps[p]);
         run_rows(BYTES_PER_PHASE);
      end

      if (beats.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
